// ===== hdl/ble_pkg.sv =====
// ble_pkg: shared types and codes for the bounded list engine.
// Used by every module of the block but ble_ram; no dependencies.

package ble_pkg;

	// operation codes carried in the func field
	localparam logic [2:0] FN_INSERT = 3'd0;
	localparam logic [2:0] FN_REMOVE = 3'd1;
	localparam logic [2:0] FN_MAX    = 3'd2;
	localparam logic [2:0] FN_READ   = 3'd3;
	localparam logic [2:0] FN_CLEAR  = 3'd4;

	typedef struct packed {
		logic [2:0]         func;
		logic signed [31:0] value_in;
		logic [4:0]         position;
	} ble_in_t;

	typedef struct packed {
		logic               ok;
		logic signed [31:0] value_out;
		logic [4:0]         count;
		logic               empty_res;
	} ble_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN,
		ST_SHIFT,
		ST_FINISH
	} ble_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic read_pos;
		logic scan_init;
		logic scan;
		logic shift_init;
		logic shift;
		logic commit;
	} ble_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [2:0] func;
		logic       cnt_zero;
		logic       scan_done;
		logic       hit;
		logic       shift_done;
		logic       out_free;
	} ble_sts_t;

endpackage

// ===== hdl/bounded_list_engine_core.sv =====
// bounded_list_engine_core: top level of the bounded list engine.
// Depends on ble_pkg, ble_ctrl, ble_dp (which holds ble_ram).
//
// Usage
//   Request channel (req_valid / req_stall / req): one beat carries func,
//   value_in and position. A beat is taken when req_valid is high and
//   req_stall is low; req_stall is low only while the engine is idle.
//   Response channel (rsp_valid / rsp_stall / rsp): exactly one beat per
//   request with ok, value_out, count and empty_res, in request order.
//   Sequence, accept edge to response valid:
//     insert, read, clear, unused codes: dispatch, finish
//     remove-value / remove-max: dispatch, scan (skipped on an empty
//     list), gap closing when an entry was found, finish. Scan and gap
//     closing each walk the entry RAM one address per cycle through its
//     single read port.
//   One request is in flight at a time; the next one is taken the cycle
//   after the previous result lands in the response register, even if not
//   yet taken.
//   Receiver stall: the response register holds its beat; a finished
//   operation waits in its last state until the register frees up.
//   Reset (arst_n low): count goes to zero, the list reads empty. The RAM
//   is not cleared; only entries below the count are ever used in a result.

module bounded_list_engine_core #(
	parameter int DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  ble_pkg::ble_in_t req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output ble_pkg::ble_out_t rsp
);

	ble_pkg::ble_cmd_t cmd;
	ble_pkg::ble_sts_t sts;

	// sequencing: idle, dispatch, scan, shift, finish
	ble_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// entry store, pointers and the response register
	ble_dp #(.DEPTH(DEPTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall)
	);

endmodule

// ===== hdl/ble_ram.sv =====
// ble_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module ble_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/ble_ctrl.sv =====
// ble_ctrl: sequencing state machine of the bounded list engine.
// Depends on ble_pkg; drives commands into ble_dp and reads its status.

module ble_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  ble_pkg::ble_sts_t sts,
	output ble_pkg::ble_cmd_t cmd
);

	ble_pkg::ble_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ble_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ble_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = ble_pkg::ST_DISPATCH;
				end
			end
			ble_pkg::ST_DISPATCH: begin
				if ((sts.func == ble_pkg::FN_REMOVE || sts.func == ble_pkg::FN_MAX)
						&& !sts.cnt_zero) begin
					state_d = ble_pkg::ST_SCAN;
				end else begin
					state_d = ble_pkg::ST_FINISH;
				end
			end
			ble_pkg::ST_SCAN: begin
				if (sts.scan_done) begin
					state_d = sts.hit ? ble_pkg::ST_SHIFT : ble_pkg::ST_FINISH;
				end
			end
			ble_pkg::ST_SHIFT: begin
				if (sts.shift_done) begin
					state_d = ble_pkg::ST_FINISH;
				end
			end
			ble_pkg::ST_FINISH: begin
				if (sts.out_free) begin
					state_d = ble_pkg::ST_IDLE;
				end
			end
			default: state_d = ble_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			ble_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				cmd.load  = req_valid;
			end
			ble_pkg::ST_DISPATCH: begin
				cmd.read_pos  = (sts.func == ble_pkg::FN_READ);
				cmd.scan_init = (sts.func == ble_pkg::FN_REMOVE || sts.func == ble_pkg::FN_MAX)
						&& !sts.cnt_zero;
			end
			ble_pkg::ST_SCAN: begin
				cmd.scan       = 1'b1;
				cmd.shift_init = sts.scan_done && sts.hit;
			end
			ble_pkg::ST_SHIFT: begin
				cmd.shift = 1'b1;
			end
			ble_pkg::ST_FINISH: begin
				cmd.commit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== hdl/ble_dp.sv =====
// ble_dp: datapath of the bounded list engine: entry store, count, scan and
// gap-closing pointers, result register. Depends on ble_pkg and ble_ram.

module ble_dp #(
	parameter int DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ble_pkg::ble_in_t  req,
	input  ble_pkg::ble_cmd_t cmd,
	output ble_pkg::ble_sts_t sts,
	output ble_pkg::ble_out_t rsp,
	output logic              rsp_valid,
	input  logic              rsp_stall
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > 5) ? CW : 5;

	// list is stored oldest-first: head (position 1) sits at address count-1
	logic [2:0]    func_q;
	logic [31:0]   val_q;
	logic [4:0]    pos_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] ptr_q;
	logic          issue_q;
	logic          arr_vld_s1;
	logic [AW-1:0] arr_addr_s1;
	logic          found_q;
	logic [31:0]   best_q;
	logic [AW-1:0] best_addr_q;
	ble_pkg::ble_out_t rsp_q;
	logic          rsp_valid_q;

	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [31:0]   ram_wdata, rd_data;

	logic          greater, match, full, pos_ok, out_free;
	logic [AW-1:0] best_addr_nx;
	logic [CW-1:0] shift_start, cnt_m1, cnt_c;
	logic [PW-1:0] pos_x, cnt_x, rd_pos_addr;
	logic          ok_c;
	logic [31:0]   vout_c;

	ble_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	assign greater = $signed(rd_data) > $signed(best_q);
	assign match   = arr_vld_s1 && ((func_q == ble_pkg::FN_REMOVE)
			? (!found_q && rd_data == val_q)
			: (!found_q || greater));
	assign best_addr_nx = match ? arr_addr_s1 : best_addr_q;
	assign shift_start  = CW'(best_addr_nx) + 1'b1;
	assign cnt_m1       = cnt_q - 1'b1;
	assign full         = cnt_q >= CW'(DEPTH);
	assign pos_x        = PW'(pos_q);
	assign cnt_x        = PW'(cnt_q);
	assign rd_pos_addr  = cnt_x - pos_x;
	assign pos_ok       = (pos_x != '0) && (pos_x <= cnt_x);
	assign out_free     = !rsp_valid_q || !rsp_stall;

	assign sts.func       = func_q;
	assign sts.cnt_zero   = (cnt_q == '0);
	assign sts.scan_done  = arr_vld_s1 && (arr_addr_s1 == '0
			|| (func_q == ble_pkg::FN_REMOVE && match));
	assign sts.hit        = found_q || match;
	assign sts.shift_done = !issue_q && !arr_vld_s1;
	assign sts.out_free   = out_free;

	// store port steering
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = '0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = val_q;
		if (cmd.read_pos) begin
			ram_re    = 1'b1;
			ram_raddr = rd_pos_addr[AW-1:0];
		end
		if ((cmd.scan || cmd.shift) && issue_q) begin
			ram_re    = 1'b1;
			ram_raddr = ptr_q[AW-1:0];
		end
		if (cmd.shift && arr_vld_s1) begin
			ram_we    = 1'b1;
			ram_waddr = arr_addr_s1 - 1'b1;
			ram_wdata = rd_data;
		end
		if (cmd.commit && func_q == ble_pkg::FN_INSERT && !full) begin
			ram_we    = 1'b1;
			ram_waddr = cnt_q[AW-1:0];
			ram_wdata = val_q;
		end
	end

	// result of the finished operation
	always_comb begin
		ok_c   = 1'b0;
		vout_c = '0;
		cnt_c  = cnt_q;
		case (func_q)
			ble_pkg::FN_INSERT: begin
				if (!full) begin
					ok_c  = 1'b1;
					cnt_c = cnt_q + 1'b1;
				end
			end
			ble_pkg::FN_REMOVE: begin
				if (found_q) begin
					ok_c  = 1'b1;
					cnt_c = cnt_m1;
				end
			end
			ble_pkg::FN_MAX: begin
				if (found_q) begin
					ok_c   = 1'b1;
					vout_c = best_q;
					cnt_c  = cnt_m1;
				end
			end
			ble_pkg::FN_READ: begin
				if (pos_ok) begin
					ok_c   = 1'b1;
					vout_c = rd_data;
				end
			end
			ble_pkg::FN_CLEAR: begin
				ok_c  = 1'b1;
				cnt_c = '0;
			end
			default: begin
				ok_c = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ptr_q       <= '0;
			issue_q     <= 1'b0;
			arr_vld_s1  <= 1'b0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				found_q <= 1'b0;
			end
			if (cmd.scan_init) begin
				ptr_q      <= cnt_m1;
				issue_q    <= 1'b1;
				arr_vld_s1 <= 1'b0;
				found_q    <= 1'b0;
			end else if (cmd.shift_init) begin
				ptr_q      <= shift_start;
				issue_q    <= shift_start < cnt_q;
				arr_vld_s1 <= 1'b0;
			end else if (cmd.scan) begin
				// walk from the head toward the oldest entry
				arr_vld_s1 <= issue_q;
				if (issue_q) begin
					ptr_q <= ptr_q - 1'b1;
					if (ptr_q == '0) begin
						issue_q <= 1'b0;
					end
				end
			end else if (cmd.shift) begin
				// move newer entries down one slot over the gap
				arr_vld_s1 <= issue_q;
				if (issue_q) begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == cnt_m1) begin
						issue_q <= 1'b0;
					end
				end
			end
			if (cmd.scan && match) begin
				found_q <= 1'b1;
			end
			if (cmd.commit) begin
				cnt_q       <= cnt_c;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= req.func;
			val_q  <= req.value_in;
			pos_q  <= req.position;
		end
		if ((cmd.scan || cmd.shift) && issue_q) begin
			arr_addr_s1 <= ptr_q[AW-1:0];
		end
		if (cmd.scan && match) begin
			best_q      <= rd_data;
			best_addr_q <= arr_addr_s1;
		end
		if (cmd.commit) begin
			rsp_q.ok        <= ok_c;
			rsp_q.value_out <= vout_c;
			rsp_q.count     <= 5'(cnt_c);
			rsp_q.empty_res <= (cnt_c == '0);
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

// ===== hdl/ble_checker.sv =====
// ble_checker: port-level checks for bounded_list_engine_core, bound in.
// Depends on ble_pkg and the top level's ports.

module ble_checker #(
	parameter int DEPTH = 16
) (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input ble_pkg::ble_in_t  req,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input ble_pkg::ble_out_t rsp
);

	// a held response beat stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// a failed operation reports a zero value
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.ok |-> rsp.value_out == 32'sd0)
		else $error("nonzero value on failure");

	// count stays in range and agrees with the empty flag (checked for DEPTH below 32)
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (DEPTH >= 32)
			|| (rsp.count <= DEPTH && rsp.empty_res == (rsp.count == 5'd0)))
		else $error("count out of range or empty flag wrong");

	// one request at a time: the engine stalls right after a take
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second request taken back to back");

endmodule

bind bounded_list_engine_core ble_checker #(.DEPTH(DEPTH)) u_ble_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
